>>> src/calc_pkg.sv
// Shared types and constants for the card access list controller.
// Used by card_access_list_controller and tb_top; no dependencies.
`timescale 1ns / 1ps

package calc_pkg;

  localparam int ID_W            = 40;
  localparam int ACT_W           = 4;
  localparam int STORED_W        = 7;
  localparam int TABLE_DEPTH_DEF = 64;

  typedef enum logic [1:0] {
    MODE_NOMASTER = 2'd0,
    MODE_NORMAL   = 2'd1,
    MODE_MENU     = 2'd2,
    MODE_ARMED    = 2'd3
  } mode_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_IGNORED  = 4'd0,
    ACT_ENROLLED = 4'd1,
    ACT_GRANTED  = 4'd2,
    ACT_DENIED   = 4'd3,
    ACT_MENU     = 4'd4,
    ACT_SAVED    = 4'd5,
    ACT_ADDED    = 4'd6,
    ACT_FULL     = 4'd7,
    ACT_EXIT     = 4'd8,
    ACT_CLEARED  = 4'd9,
    ACT_CANCEL   = 4'd10,
    ACT_ARMED    = 4'd11,
    ACT_OPEN     = 4'd12
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DECIDE = 2'd1,
    ST_SCAN   = 2'd2,
    ST_EMIT   = 2'd3
  } state_t;

endpackage

>>> src/card_access_list_controller.sv
// Card access list controller: master enrolment, menu and ID table lookup.
// Depends on calc_pkg and calc_ram.
`timescale 1ns / 1ps
//
//  channel   dir  tvalid/tready  payload
//  s_axis    in   yes            tdata: card_id[39:0]; tuser: cmd[0]
//  m_axis    out  yes            tdata: action[3:0], lock_open[4], stored_count[11:5]
//
// A button item, or a card that needs no lookup, goes from accept through
// the DECIDE and EMIT states to the output register. A lookup adds the SCAN state: the table has one
// read port and is walked one entry per cycle, stopping at the first match.
// Reset (rst, synchronous) gives no master, empty table; no clearing pass.
// The result sits in an output register; a stalled m_axis holds the block
// before its state update, and the next item is taken once back in idle.

module card_access_list_controller #(
  parameter int TABLE_DEPTH = calc_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // card_id[39:0]
  input  logic [0:0]  s_axis_tuser,  // cmd[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // action[3:0], lock_open[4], stored_count[11:5]
);

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int ID_W   = calc_pkg::ID_W;
  localparam int SW     = calc_pkg::STORED_W;
  localparam int ACT_W  = calc_pkg::ACT_W;

  calc_pkg::state_t state, state_next;
  calc_pkg::mode_t  mode, mode_next;

  logic [ID_W-1:0]  master_id, master_id_next;
  logic [CNT_W-1:0] entry_count, entry_count_next;
  logic             btn;
  logic [ID_W-1:0]  id_q;
  logic [CNT_W-1:0] issue_cnt;
  logic             rd_pend;
  logic             hit;

  logic             in_acc, need_scan, can_emit, emit, ram_re, ram_we, hit_now;
  logic [ID_W-1:0]  ram_rdata;
  calc_pkg::act_t   act;
  logic [15:0]      out_data;
  logic [CNT_W+SW-1:0] cnt_ext;

  assign s_axis_tready = (state == calc_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign can_emit      = !m_axis_tvalid || m_axis_tready;
  assign hit_now       = rd_pend && (ram_rdata == id_q);

  assign need_scan = !btn && (mode == calc_pkg::MODE_NORMAL || mode == calc_pkg::MODE_MENU)
                     && (id_q != master_id) && (entry_count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= calc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, table read issue and the output commit
  always_comb begin
    state_next = state;
    ram_re     = 1'b0;
    emit       = 1'b0;
    case (state)
      calc_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_next = calc_pkg::ST_DECIDE;
        end
      end
      calc_pkg::ST_DECIDE: begin
        state_next = need_scan ? calc_pkg::ST_SCAN : calc_pkg::ST_EMIT;
      end
      calc_pkg::ST_SCAN: begin
        if (hit_now || (rd_pend && issue_cnt == entry_count)) begin
          state_next = calc_pkg::ST_EMIT;
        end else begin
          ram_re = (issue_cnt < entry_count);
        end
      end
      calc_pkg::ST_EMIT: begin
        if (can_emit) begin
          emit       = 1'b1;
          state_next = calc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = calc_pkg::ST_IDLE;
      end
    endcase
  end

  // step outcome from the latched item, current state and lookup result
  always_comb begin
    act              = calc_pkg::ACT_IGNORED;
    mode_next        = mode;
    master_id_next   = master_id;
    entry_count_next = entry_count;
    ram_we           = 1'b0;
    case (mode)
      calc_pkg::MODE_NOMASTER: begin
        if (!btn) begin
          master_id_next = id_q;
          mode_next      = calc_pkg::MODE_NORMAL;
          act            = calc_pkg::ACT_ENROLLED;
        end
      end
      calc_pkg::MODE_NORMAL: begin
        if (btn) begin
          act = calc_pkg::ACT_OPEN;
        end else if (id_q == master_id) begin
          mode_next = calc_pkg::MODE_MENU;
          act       = calc_pkg::ACT_MENU;
        end else if (hit) begin
          act = calc_pkg::ACT_GRANTED;
        end else begin
          act = calc_pkg::ACT_DENIED;
        end
      end
      calc_pkg::MODE_MENU: begin
        if (btn) begin
          mode_next = calc_pkg::MODE_ARMED;
          act       = calc_pkg::ACT_ARMED;
        end else if (id_q == master_id) begin
          mode_next = calc_pkg::MODE_NORMAL;
          act       = calc_pkg::ACT_EXIT;
        end else if (hit) begin
          act = calc_pkg::ACT_SAVED;
        end else if (entry_count < CNT_W'(TABLE_DEPTH)) begin
          ram_we           = emit;
          entry_count_next = entry_count + CNT_W'(1);
          act              = calc_pkg::ACT_ADDED;
        end else begin
          act = calc_pkg::ACT_FULL;
        end
      end
      default: begin
        if (!btn) begin
          if (id_q == master_id) begin
            // table contents are left; count zero makes them unreachable
            master_id_next   = '0;
            entry_count_next = '0;
            mode_next        = calc_pkg::MODE_NOMASTER;
            act              = calc_pkg::ACT_CLEARED;
          end else begin
            mode_next = calc_pkg::MODE_NORMAL;
            act       = calc_pkg::ACT_CANCEL;
          end
        end
      end
    endcase
  end

  assign cnt_ext = {{SW{1'b0}}, entry_count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= calc_pkg::MODE_NOMASTER;
      master_id     <= '0;
      entry_count   <= '0;
      m_axis_tvalid <= 1'b0;
      rd_pend       <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (emit) begin
        mode          <= mode_next;
        master_id     <= master_id_next;
        entry_count   <= entry_count_next;
        m_axis_tvalid <= 1'b1;
      end
      rd_pend <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      btn  <= s_axis_tuser[0];
      id_q <= s_axis_tdata;
    end
    if (state == calc_pkg::ST_DECIDE) begin
      issue_cnt <= '0;
      hit       <= 1'b0;
    end else begin
      if (ram_re) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
      end
      if (hit_now && state == calc_pkg::ST_SCAN) begin
        hit <= 1'b1;
      end
    end
    if (emit) begin
      out_data <= {4'b0000, cnt_ext[SW-1:0], mode_next != calc_pkg::MODE_NORMAL,
                   ACT_W'(act)};
    end
  end

  assign m_axis_tdata = out_data;

  calc_ram #(
    .WIDTH  (ID_W),
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entry_count[ADDR_W-1:0]),
    .wdata (id_q),
    .re    (ram_re),
    .raddr (issue_cnt[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_write_in_menu: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == calc_pkg::ST_EMIT && mode == calc_pkg::MODE_MENU && !btn))
    else $error("table write outside menu add");

  a_nomaster_empty: assert property (@(posedge clk) disable iff (rst)
    mode == calc_pkg::MODE_NOMASTER |-> entry_count == '0)
    else $error("entries held with no master");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_re |-> (issue_cnt < entry_count && state == calc_pkg::ST_SCAN))
    else $error("table read beyond filled entries");

endmodule

>>> src/calc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module calc_ram #(
  parameter int WIDTH  = 40,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> tb/tb_top.sv
// Self-checking bench for card_access_list_controller: directed and random
// card and button items, checked against a behavioural copy of the block.
// Depends on calc_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int DEPTH     = 64;
  localparam int N_RANDOM  = 800;
  localparam int CALM_FROM = 300;
  localparam int CALM_TO   = 420;
  localparam int HOLD_AT   = 550;
  localparam int HOLD_LEN  = 400;
  localparam int DRAIN     = 100;

  typedef struct packed {
    calc_pkg::act_t action;
    logic           lock_open;
    logic [6:0]     stored;
  } outcome_t;

  // Tracks the controller state and the results still owed by the block.
  class access_checker;
    calc_pkg::mode_t mode;
    logic [39:0]     master;
    logic [39:0]     ids[DEPTH];
    int              count;
    outcome_t        due_outcomes[$];
    int              errors;

    function new();
      mode   = calc_pkg::MODE_NOMASTER;
      master = '0;
      count  = 0;
      errors = 0;
    endfunction

    function bit is_listed(logic [39:0] id);
      for (int k = 0; k < count; k++)
        if (ids[k] == id) return 1'b1;
      return 1'b0;
    endfunction

    function void note_event(bit button, logic [39:0] id);
      outcome_t o;
      o.action = calc_pkg::ACT_IGNORED;
      case (mode)
        calc_pkg::MODE_NOMASTER: begin
          if (!button) begin
            master   = id;
            mode     = calc_pkg::MODE_NORMAL;
            o.action = calc_pkg::ACT_ENROLLED;
          end
        end
        calc_pkg::MODE_NORMAL: begin
          if (button) o.action = calc_pkg::ACT_OPEN;
          else if (id == master) begin
            mode     = calc_pkg::MODE_MENU;
            o.action = calc_pkg::ACT_MENU;
          end else if (is_listed(id)) o.action = calc_pkg::ACT_GRANTED;
          else o.action = calc_pkg::ACT_DENIED;
        end
        calc_pkg::MODE_MENU: begin
          if (button) begin
            mode     = calc_pkg::MODE_ARMED;
            o.action = calc_pkg::ACT_ARMED;
          end else if (id == master) begin
            mode     = calc_pkg::MODE_NORMAL;
            o.action = calc_pkg::ACT_EXIT;
          end else if (is_listed(id)) o.action = calc_pkg::ACT_SAVED;
          else if (count < DEPTH) begin
            ids[count] = id;
            count++;
            o.action = calc_pkg::ACT_ADDED;
          end else o.action = calc_pkg::ACT_FULL;
        end
        default: begin
          if (!button) begin
            if (id == master) begin
              master   = '0;
              count    = 0;
              mode     = calc_pkg::MODE_NOMASTER;
              o.action = calc_pkg::ACT_CLEARED;
            end else begin
              mode     = calc_pkg::MODE_NORMAL;
              o.action = calc_pkg::ACT_CANCEL;
            end
          end
        end
      endcase
      o.lock_open = (mode != calc_pkg::MODE_NORMAL);
      o.stored    = count[6:0];
      due_outcomes.push_back(o);
    endfunction

    function void check_outcome(logic [15:0] tdata);
      outcome_t o;
      if (due_outcomes.size() == 0) begin
        $display("%0t: unexpected item, actual tdata %h", $time, tdata);
        errors++;
        return;
      end
      o = due_outcomes.pop_front();
      if (tdata[3:0] != o.action) begin
        $display("%0t: action expected %0d actual %0d", $time, o.action, tdata[3:0]);
        errors++;
      end
      if (tdata[4] != o.lock_open) begin
        $display("%0t: lock_open expected %0d actual %0d", $time, o.lock_open, tdata[4]);
        errors++;
      end
      if (tdata[11:5] != o.stored) begin
        $display("%0t: stored_count expected %0d actual %0d", $time, o.stored,
                 tdata[11:5]);
        errors++;
      end
      if (tdata[15:12] != 4'd0) begin
        $display("%0t: pad bits expected 0 actual %h", $time, tdata[15:12]);
        errors++;
      end
    endfunction

    function int pending();
      return due_outcomes.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // card_id[39:0]
  logic [0:0]  s_axis_tuser = '0;   // cmd[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // action[3:0], lock_open[4], stored_count[11:5]

  access_checker sb = new();
  int            items_sent = 0;
  int            hold_left = 0;
  bit            held_off = 1'b0;

  card_access_list_controller #(.TABLE_DEPTH(DEPTH)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function bit calm();
    return items_sent >= CALM_FROM && items_sent < CALM_TO;
  endfunction

  function logic [39:0] any_id();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[39:0];
  endfunction

  task automatic send_item(bit button, logic [39:0] id);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= button;
    s_axis_tdata  <= id;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_event(button, id);
    items_sent++;
    if (!calm() && $urandom_range(99) < 28) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Well-formed traffic for the current mode, with random IDs mixed in.
  // While filling, the menu mostly adds fresh cards and clears are rare.
  function void pick_event(bit filling, output bit button, output logic [39:0] id);
    int r;
    logic [39:0] listed_id;
    r         = $urandom_range(99);
    button    = 1'b0;
    id        = any_id();
    listed_id = (sb.count > 0) ? sb.ids[$urandom_range(sb.count - 1)] : id;
    case (sb.mode)
      calc_pkg::MODE_NOMASTER: begin
        if (r < 15) button = 1'b1;
        else if (r < 22) id = '1;
        else if (r < 28) id = '0;
      end
      calc_pkg::MODE_NORMAL: begin
        if (r < 18) button = 1'b1;
        else if (r < 33) id = sb.master;
        else if (r < 63) id = listed_id;
        else if (r < 75) id = sb.master ^ (40'd1 << $urandom_range(39));
      end
      calc_pkg::MODE_MENU: begin
        if (filling) begin
          if (r < 4) button = 1'b1;
          else if (r < 12) id = sb.master;
          else if (r < 22) id = listed_id;
        end else begin
          if (r < 15) button = 1'b1;
          else if (r < 35) id = sb.master;
          else if (r < 55) id = listed_id;
        end
      end
      default: begin
        if (r < 25) button = 1'b1;
        else if (r < (filling ? 28 : 65)) id = sb.master;
        else if (r < 80) id = listed_id;
      end
    endcase
  endfunction

  task automatic run_directed();
    send_item(1'b1, '1);           // button with no master
    send_item(1'b0, '1);           // all-ones card becomes master
    send_item(1'b0, '0);
    send_item(1'b1, 40'h00_0000_0000);
    send_item(1'b0, '1);           // into menu
    send_item(1'b0, '0);
    send_item(1'b0, '0);           // already held
    send_item(1'b0, 40'hFF_FFFF_FFFE);
    send_item(1'b0, '1);           // out of menu
    send_item(1'b0, '0);
    send_item(1'b0, 40'hFF_FFFF_FFFE);
    send_item(1'b0, 40'h80_0000_0000);
    send_item(1'b0, '1);
    send_item(1'b1, 40'h55_AA55_AA55);
    send_item(1'b1, '1);           // button while armed is ignored
    send_item(1'b0, 40'h00_0000_0001);  // cancel
    send_item(1'b0, '1);
    send_item(1'b1, '0);
    send_item(1'b0, '1);           // master wipes everything
    send_item(1'b0, '0);           // zero ID as master
    send_item(1'b0, '0);
    send_item(1'b0, '0);
  endtask

  task automatic run_random();
    bit          button;
    logic [39:0] id;
    for (int n = 0; n < N_RANDOM; n++) begin
      pick_event(n < 350, button, id);
      send_item(button, id);
    end
  endtask

  // Result side: random back-pressure, one long hold-off to back the block up.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) sb.check_outcome(m_axis_tdata);
      if (!held_off && items_sent >= HOLD_AT) begin
        held_off  = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (calm()) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 28);
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
